@@ sv/bitmap_block_allocator_assert.svh @@
// Assertion macros used by the allocator top level.
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and helpers of the bitmap block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

  localparam int NUM_W       = 11;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam int DEF_POOL_ENTRIES = 1024;
  localparam int DEF_WORD_BITS    = 32;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic init;  // clearing sweep after reset in progress
    logic busy;  // an accepted request is still being worked on
  } bba_status_t;

  // Leading-zero count of a 64-bit word by halving; meaningful for v != 0.
  function automatic logic [5:0] lead_zeros64(input logic [63:0] v);
    logic [63:0] w;
    logic [5:0]  n;
    w = v;
    n = '0;
    if (w[63:32] == '0) begin
      n[5] = 1'b1;
      w    = w << 32;
    end
    if (w[63:48] == '0) begin
      n[4] = 1'b1;
      w    = w << 16;
    end
    if (w[63:56] == '0) begin
      n[3] = 1'b1;
      w    = w << 8;
    end
    if (w[63:60] == '0) begin
      n[2] = 1'b1;
      w    = w << 4;
    end
    if (w[63:62] == '0) begin
      n[1] = 1'b1;
      w    = w << 2;
    end
    if (w[63] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

endpackage

@@ sv/bba_ram.sv @@
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual-port bitmap store, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clearing sweep, word scan for allocate, word walk and
// read-modify-write for free, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_ctrl import bba_pkg::*; #(
  parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
  parameter int WORD_BITS    = DEF_WORD_BITS,
  parameter int WORD_COUNT   = (POOL_ENTRIES + WORD_BITS - 1) / WORD_BITS,
  parameter int AW           = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic                 req_mode_i,
  input  logic [NUM_W-1:0]     req_number_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [NUM_W-1:0]     res_number_o,
  output logic [STAT_W-1:0]    res_status_o,
  output logic                 mem_wr_en_o,
  output logic [AW-1:0]        mem_wr_addr_o,
  output logic [WORD_BITS-1:0] mem_wr_data_o,
  output logic                 mem_rd_en_o,
  output logic [AW-1:0]        mem_rd_addr_o,
  input  logic [WORD_BITS-1:0] mem_rd_data_i,
  output bba_status_t          status_o
);

  localparam int BW        = $clog2(WORD_BITS);
  localparam int IW        = $clog2(WORD_COUNT * WORD_BITS + 1);
  localparam int LAST_BITS = POOL_ENTRIES - (WORD_COUNT - 1) * WORD_BITS;
  localparam logic [AW-1:0]        LAST_ADDR = AW'(WORD_COUNT - 1);
  localparam logic [WORD_BITS-1:0] ALL_ONES  = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] LAST_MASK = ~(ALL_ONES >> LAST_BITS);
  localparam logic [WORD_BITS-1:0] WORD_ONE  = WORD_BITS'(1);
  localparam logic [BW-1:0]        TOP_BIT   = BW'(WORD_BITS - 1);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ASCAN  = 3'd2;
  localparam logic [2:0] ST_FWALK  = 3'd3;
  localparam logic [2:0] ST_FCHECK = 3'd4;
  localparam logic [2:0] ST_PUSH   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [IW-1:0]     base_q, base_d;
  logic [IW-1:0]     rem_q, rem_d;
  logic [NUM_W-1:0]  pend_num_q, pend_num_d;
  logic [STAT_W-1:0] pend_st_q, pend_st_d;
  logic              out_valid_q;
  logic [NUM_W-1:0]  out_num_q;
  logic [STAT_W-1:0] out_st_q;
  logic              out_load;

  logic                 accept;
  logic [WORD_BITS-1:0] free_mask;
  logic                 any_free;
  logic [5:0]           lz;
  logic [BW-1:0]        set_pos;
  logic [BW-1:0]        clr_pos;
  logic [WORD_BITS-1:0] set_mask;
  logic [WORD_BITS-1:0] clr_mask;
  logic [IW:0]          grant_w;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  // Spare bits past the pool end never count as free.
  assign free_mask = ~mem_rd_data_i & ((addr_q == LAST_ADDR) ? LAST_MASK : ALL_ONES);
  assign any_free  = |free_mask;
  assign lz        = lead_zeros64(64'(free_mask) << (64 - WORD_BITS));
  assign set_pos   = TOP_BIT - BW'(lz);
  assign set_mask  = WORD_ONE << set_pos;
  assign clr_pos   = TOP_BIT - rem_q[BW-1:0];
  assign clr_mask  = WORD_ONE << clr_pos;
  assign grant_w   = {1'b0, base_q} + (IW + 1)'(lz) + (IW + 1)'(1);

  always_comb begin
    state_d       = state_q;
    addr_d        = addr_q;
    base_d        = base_q;
    rem_d         = rem_q;
    pend_num_d    = pend_num_q;
    pend_st_d     = pend_st_q;
    out_load      = 1'b0;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = addr_q;
    mem_wr_data_o = mem_rd_data_i;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = addr_q;
    case (state_q)
      ST_INIT: begin
        mem_wr_en_o   = 1'b1;
        mem_wr_data_o = '0;
        if (addr_q == LAST_ADDR) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          addr_d     = '0;
          base_d     = '0;
          pend_num_d = '0;
          if (req_mode_i == MODE_ALLOC) begin
            mem_rd_en_o   = 1'b1;
            mem_rd_addr_o = '0;
            state_d       = ST_ASCAN;
          end else if (req_number_i == '0 ||
                       32'(req_number_i) > 32'(POOL_ENTRIES)) begin
            pend_st_d = STAT_BAD;
            state_d   = ST_PUSH;
          end else begin
            rem_d   = IW'(req_number_i - NUM_W'(1));
            state_d = ST_FWALK;
          end
        end
      end
      ST_ASCAN: begin
        if (any_free) begin
          mem_wr_en_o   = 1'b1;
          mem_wr_data_o = mem_rd_data_i | set_mask;
          pend_num_d    = NUM_W'(grant_w);
          pend_st_d     = STAT_OK;
          state_d       = ST_PUSH;
        end else if (addr_q == LAST_ADDR) begin
          pend_num_d = '0;
          pend_st_d  = STAT_FULL;
          state_d    = ST_PUSH;
        end else begin
          // advance to the next word and fetch it
          addr_d        = addr_q + AW'(1);
          base_d        = base_q + IW'(WORD_BITS);
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = addr_q + AW'(1);
        end
      end
      ST_FWALK: begin
        if (rem_q >= IW'(WORD_BITS)) begin
          rem_d  = rem_q - IW'(WORD_BITS);
          addr_d = addr_q + AW'(1);
        end else begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = addr_q;
          state_d       = ST_FCHECK;
        end
      end
      ST_FCHECK: begin
        if ((mem_rd_data_i & clr_mask) != '0) begin
          mem_wr_en_o   = 1'b1;
          mem_wr_data_o = mem_rd_data_i & ~clr_mask;
          pend_st_d     = STAT_OK;
        end else begin
          pend_st_d = STAT_BAD;
        end
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        // hold until the result register can take the transfer
        if (!out_valid_q || res_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    rem_q      <= rem_d;
    pend_num_q <= pend_num_d;
    pend_st_q  <= pend_st_d;
    if (out_load) begin
      out_num_q <= pend_num_q;
      out_st_q  <= pend_st_q;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign res_number_o  = out_num_q;
  assign res_status_o  = out_st_q;
  assign status_o.init = (state_q == ST_INIT);
  assign status_o.busy = (state_q != ST_INIT) && (state_q != ST_IDLE);

endmodule

@@ sv/bitmap_block_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Free-entry bitmap allocator: allocate lowest free entry, free a given entry.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the mode (0 allocate,
//   1 free), tdata the one-based entry number to free. Each request gives one
//   result on m_axis: granted number and status (0 ok, 1 full, 2 bad/free).
//   The bitmap sits in a WORD_BITS-wide memory of ceil(POOL_ENTRIES/WORD_BITS)
//   words, read one word per cycle. Allocate scans the words in order until
//   one holds a free entry or the last is reached (1 up to the word count, 32
//   by default, words scanned) and sets the lowest free bit; free walks to the
//   entry's word one word per cycle, then reads it and, if the entry is taken,
//   writes it back with the bit cleared; a bad number goes straight to the
//   result. One request is in work at a time; s_axis_tready is high only when
//   idle. After reset a clearing sweep writes every word to zero, one per
//   cycle, with s_axis_tready low.
//   The result sits in an output register; a stalled receiver holds it, the
//   next request is still taken and waits for the register before finishing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_block_allocator import bba_pkg::*; #(
  parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
  parameter int WORD_BITS    = DEF_WORD_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [10:0] entry_number
  input  logic                   s_axis_tuser,   // [0] mode
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [10:0] granted_number, [12:11] status
);

  `include "bitmap_block_allocator_assert.svh"

  localparam int WORD_COUNT = (POOL_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;
  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [WORD_BITS-1:0] mem_rd_data;
  logic [NUM_W-1:0]     res_number;
  logic [STAT_W-1:0]    res_status;
  bba_status_t          ctrl_status;

  bba_ctrl #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .WORD_BITS    (WORD_BITS),
    .WORD_COUNT   (WORD_COUNT),
    .AW           (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .req_mode_i    (s_axis_tuser),
    .req_number_i  (s_axis_tdata[NUM_W-1:0]),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_number_o  (res_number),
    .res_status_o  (res_status),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .status_o      (ctrl_status)
  );

  bba_ram #(
    .DEPTH (WORD_COUNT),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  assign m_axis_tdata = OUT_TDATA_W'({res_status, res_number});

  `BBA_ASSERT_NOW(a_no_accept_in_init, ctrl_status.init, !s_axis_tready, "request taken during clearing sweep")
  `BBA_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, ctrl_status.busy, "accepted request not in work")
  `BBA_ASSERT_NOW(a_grant_only_ok, m_axis_tvalid && res_status != STAT_OK, res_number == '0, "number granted with error status")
  `BBA_ASSERT_NOW(a_status_code, m_axis_tvalid, res_status == STAT_OK || res_status == STAT_FULL || res_status == STAT_BAD, "undefined status code")

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the bitmap block allocator. A short table of
// requests covers first grants, bad and already-free numbers; the pool is
// then filled to the top and driven in random alloc/free mixes. Every result
// is compared with the row's expectation or a bitmap model kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bba_pkg::*;

  localparam int POOL  = DEF_POOL_ENTRIES;
  localparam int WBITS = DEF_WORD_BITS;
  localparam int WORDS = (POOL + WBITS - 1) / WBITS;
  localparam int RANDOM_REQUESTS = 700;

  typedef struct packed {
    logic [NUM_W-1:0]  granted;
    logic [STAT_W-1:0] status;
  } grant_t;

  typedef struct packed {
    logic              mode;
    logic [NUM_W-1:0]  number;
    logic              typed;   // expectation given in the row
    logic [NUM_W-1:0]  granted;
    logic [STAT_W-1:0] status;
  } dir_row_t;

  localparam int DIR_ROWS = 18;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{MODE_ALLOC, 11'd0,    1'b1, 11'd1, STAT_OK},
    '{MODE_ALLOC, 11'h7FF,  1'b1, 11'd2, STAT_OK},    // number ignored on allocate
    '{MODE_FREE,  11'd0,    1'b1, 11'd0, STAT_BAD},
    '{MODE_FREE,  11'd1025, 1'b1, 11'd0, STAT_BAD},
    '{MODE_FREE,  11'h7FF,  1'b1, 11'd0, STAT_BAD},
    '{MODE_FREE,  11'd1024, 1'b1, 11'd0, STAT_BAD},   // top entry, still free
    '{MODE_FREE,  11'd1,    1'b1, 11'd0, STAT_OK},
    '{MODE_FREE,  11'd1,    1'b1, 11'd0, STAT_BAD},
    '{MODE_ALLOC, 11'h555,  1'b1, 11'd1, STAT_OK},
    '{MODE_ALLOC, 11'h2AA,  1'b1, 11'd3, STAT_OK},
    '{MODE_FREE,  11'h2AA,  1'b1, 11'd0, STAT_BAD},
    '{MODE_FREE,  11'h555,  1'b1, 11'd0, STAT_BAD},
    '{MODE_FREE,  11'd2,    1'b1, 11'd0, STAT_OK},
    '{MODE_ALLOC, 11'd0,    1'b1, 11'd2, STAT_OK},
    '{MODE_FREE,  11'd3,    1'b0, 11'd0, STAT_OK},
    '{MODE_ALLOC, 11'd9,    1'b0, 11'd0, STAT_OK},
    '{MODE_ALLOC, 11'd0,    1'b0, 11'd0, STAT_OK},
    '{MODE_FREE,  11'd4,    1'b0, 11'd0, STAT_OK}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Bench copy of the bitmap, bit WBITS-1 of each word is its lowest entry
  logic [WBITS-1:0] pool_words [WORDS];
  int               used_count;
  grant_t           pending_grants [$];
  int               mismatch_count;
  int               burst_left;

  bitmap_block_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_500_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int bit_pos(input int idx);
    return WBITS - 1 - (idx % WBITS);
  endfunction

  function automatic logic entry_taken(input int idx);
    return pool_words[idx / WBITS][bit_pos(idx)];
  endfunction

  // Apply one request to the bench bitmap and return its result
  function automatic grant_t allocator_predict(input logic mode,
                                               input logic [NUM_W-1:0] number);
    grant_t res;
    int     idx;
    res = '{granted: '0, status: STAT_OK};
    if (mode == MODE_ALLOC) begin
      idx = 0;
      while (idx < POOL && entry_taken(idx)) idx++;
      if (idx < POOL) begin
        pool_words[idx / WBITS][bit_pos(idx)] = 1'b1;
        used_count++;
        res.granted = NUM_W'(idx + 1);
      end else begin
        res.status = STAT_FULL;
      end
    end else if (number == '0 || int'(number) > POOL) begin
      res.status = STAT_BAD;
    end else if (!entry_taken(int'(number) - 1)) begin
      res.status = STAT_BAD;
    end else begin
      idx = int'(number) - 1;
      pool_words[idx / WBITS][bit_pos(idx)] = 1'b0;
      used_count--;
    end
    return res;
  endfunction

  // One-based number of a taken entry, searched from a random start
  function automatic logic [NUM_W-1:0] pick_taken();
    int idx;
    idx = $urandom_range(POOL - 1);
    repeat (POOL) begin
      if (entry_taken(idx)) return NUM_W'(idx + 1);
      idx = (idx + 1) % POOL;
    end
    return NUM_W'($urandom_range(POOL, 1));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(input logic mode, input logic [NUM_W-1:0] number,
                              input logic typed, input grant_t typed_res);
    grant_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= IN_TDATA_W'(number);
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = allocator_predict(mode, number);
    pending_grants.push_back(typed ? typed_res : predicted);
    // Close the burst with a random gap, or run on back to back
    burst_left--;
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      if ($urandom_range(3) == 0) begin
        burst_left = $urandom_range(40, 10);
      end else begin
        burst_left = $urandom_range(6, 1);
      end
      repeat ($urandom_range(7, 1)) @(posedge clk_i);
    end
  endtask

  // Result side: stall pattern that switches between four styles
  int rx_cycle = 0;
  always @(posedge clk_i) begin
    grant_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected transfer, granted", int'(m_axis_tdata[10:0]), 0);
      end else begin
        want = pending_grants.pop_front();
        if (m_axis_tdata[10:0] !== want.granted)
          report_mismatch("granted_number", int'(m_axis_tdata[10:0]), int'(want.granted));
        if (m_axis_tdata[12:11] !== want.status)
          report_mismatch("status", int'(m_axis_tdata[12:11]), int'(want.status));
      end
    end
    rx_cycle <= rx_cycle + 1;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 200) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(1) == 0);
        2: m_axis_tready <= ($urandom_range(5) == 0);
        default: m_axis_tready <= ((rx_cycle % 11) > 2);
      endcase
    end
  end

  initial begin
    grant_t none;
    logic   mode;
    int     alloc_weight;
    none = '{granted: '0, status: STAT_OK};
    mismatch_count = 0;
    used_count = 0;
    burst_left = 4;
    for (int w = 0; w < WORDS; w++) pool_words[w] = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[r])
      send_request(DIRECTED[r].mode, DIRECTED[r].number, DIRECTED[r].typed,
                   '{granted: DIRECTED[r].granted, status: DIRECTED[r].status});

    // Fill the pool to the top, then hit the full case and the word edges
    while (used_count < POOL)
      send_request(MODE_ALLOC, NUM_W'($urandom), 1'b0, none);
    send_request(MODE_ALLOC, 11'd0, 1'b1, '{granted: 11'd0, status: STAT_FULL});
    send_request(MODE_ALLOC, 11'h7FF, 1'b1, '{granted: 11'd0, status: STAT_FULL});
    send_request(MODE_FREE, 11'd1024, 1'b1, '{granted: 11'd0, status: STAT_OK});
    send_request(MODE_FREE, 11'd1024, 1'b1, '{granted: 11'd0, status: STAT_BAD});
    send_request(MODE_FREE, 11'd32, 1'b0, none);
    send_request(MODE_FREE, 11'd33, 1'b0, none);
    send_request(MODE_ALLOC, 11'd0, 1'b1, '{granted: 11'd32, status: STAT_OK});
    send_request(MODE_ALLOC, 11'd0, 1'b1, '{granted: 11'd33, status: STAT_OK});
    send_request(MODE_ALLOC, 11'd0, 1'b1, '{granted: 11'd1024, status: STAT_OK});
    send_request(MODE_ALLOC, 11'd0, 1'b0, none);

    // Random mix; alternating drain and refill phases shift the pool's fill level
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      alloc_weight = ((n / 100) % 2 == 0) ? 30 : 70;
      if ($urandom_range(99) < alloc_weight) begin
        send_request(MODE_ALLOC, NUM_W'($urandom), 1'b0, none);
      end else if ($urandom_range(99) < 80 && used_count > 0) begin
        send_request(MODE_FREE, pick_taken(), 1'b0, none);
      end else begin
        mode = MODE_FREE;
        send_request(mode, NUM_W'($urandom), 1'b0, none);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ bitmap_block_allocator.f @@
+incdir+sv
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bba_ctrl.sv
sv/bitmap_block_allocator.sv
sim/tb.sv
